// ===== hdl/kpc_pkg.sv =====
// Shared types, constants and helper functions for the k-mer prefix counter.
// No dependencies; used by kmer_prefix_counter.sv.
`default_nettype none

package kpc_pkg;

	localparam int MAX_WORD    = 6;
	localparam int TABLE_DEPTH = 8192;
	localparam int COUNT_W     = 32;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int SUM_W  = IDX_W + 1;
	localparam int WIN_W  = 2 * MAX_WORD;
	localparam int K_W    = $clog2(MAX_WORD + 1);
	localparam int CFG_W  = 3;
	localparam int CIDX_W = 1;

	localparam logic [1:0] KIND_BASE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [CIDX_W-1:0] REG_WORD_ORDER = 1'd0;
	localparam logic [CIDX_W-1:0] REG_CODON_MODE = 1'd1;

	typedef logic [K_W-1:0]     klen_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [COUNT_W-1:0] count_t;

	// First table index of words of length k: (4^k - 1)/3
	function automatic sum_t length_offset(input klen_t k);
		sum_t off;
		sum_t p;
		off = '0;
		p   = sum_t'(1);
		for (int i = 0; i < MAX_WORD; i++) begin
			if (klen_t'(i) < k) begin
				off = off + p;
			end
			p = p << 2;
		end
		return off;
	endfunction

	// Residue mod 3 of a short word length, one bit a step
	function automatic logic [1:0] mod3(input klen_t v);
		logic [2:0] r;
		r = '0;
		for (int i = K_W - 1; i >= 0; i--) begin
			r = {r[1:0], v[i]};
			if (r >= 3'd3) begin
				r = r - 3'd3;
			end
		end
		return r[1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/kmer_prefix_counter.sv =====
// K-mer prefix counter: base window, bump sequencer and the count table memory.
// Depends on kpc_pkg for constants, types and the offset and mod-3 helpers.
//
// Occupancy: in plain mode a base item that completes a word holds the block
// for one table read-modify-write per prefix plus the root entry, then a drain;
// in codon mode, if the codon is counted, it walks down to the 3-mer, bumps
// that entry and drains. Other items do not hold it. A read holds the block
// until the result register takes its result. The single table port sets this.
// Reset: control state clears at once; then a clearing pass writes zero to all
// 8192 table entries, one per cycle, while in_stall stays high.
`default_nettype none

module kmer_prefix_counter (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration write port
	input  wire                           cfg_we,
	input  wire [kpc_pkg::CIDX_W-1:0]     cfg_index,
	input  wire [kpc_pkg::CFG_W-1:0]      cfg_data,
	// input channel
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [1:0]                     kind,
	input  wire [1:0]                     symbol,
	input  wire [kpc_pkg::IDX_W-1:0]      read_index,
	// result channel
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [kpc_pkg::COUNT_W-1:0]   count_value,
	output logic [kpc_pkg::IDX_W-1:0]     entry_index
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_BUMP  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_RDATA = 3'd5;

	localparam int IDX_W = kpc_pkg::IDX_W;
	localparam int WIN_W = kpc_pkg::WIN_W;
	localparam int K_W   = kpc_pkg::K_W;

	localparam logic [kpc_pkg::CIDX_W-1:0] REG_WORD_ORDER_SEL = kpc_pkg::REG_WORD_ORDER;
	localparam logic [kpc_pkg::CIDX_W-1:0] REG_CODON_SEL      = kpc_pkg::REG_CODON_MODE;

	// configuration registers
	logic [2:0]       word_order_q;
	logic             codon_mode_q;

	// sequence state
	logic [WIN_W-1:0] window_q;
	kpc_pkg::klen_t   seen_q;
	logic [1:0]       phase_q;

	// sequencer
	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	kpc_pkg::klen_t   k_q;
	logic [WIN_W-1:0] code_q;
	logic             root_q;
	logic             codon_q;
	logic [IDX_W-1:0] ridx_q;

	// table memory and its write pipeline
	kpc_pkg::count_t  mem [kpc_pkg::TABLE_DEPTH];
	kpc_pkg::count_t  mem_rd_q;
	logic [IDX_W-1:0] wr_addr_q;
	logic             wr_pend_q;

	// result register
	logic             out_valid_q;
	kpc_pkg::count_t  count_q;
	logic [IDX_W-1:0] entry_q;

	logic             accept;
	logic [3:0]       wo_p1;
	kpc_pkg::klen_t   word_len;
	logic [WIN_W-1:0] window_nx;
	kpc_pkg::klen_t   seen_nx;
	logic [1:0]       phase_nx;
	logic [WIN_W-1:0] win_mask;
	kpc_pkg::sum_t    bump_sum;
	logic             bump_ok;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	kpc_pkg::count_t  mem_wd;
	logic             out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Word length, clamped to the window
	assign wo_p1    = {1'b0, word_order_q} + 4'd1;
	assign word_len = (wo_p1 > 4'(kpc_pkg::MAX_WORD)) ? K_W'(kpc_pkg::MAX_WORD)
	                                                  : K_W'(wo_p1);

	assign window_nx = {window_q[WIN_W-3:0], symbol};
	assign seen_nx   = (seen_q == K_W'(kpc_pkg::MAX_WORD)) ? seen_q : seen_q + K_W'(1);
	assign phase_nx  = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
	assign win_mask  = {WIN_W{1'b1}} >> (WIN_W - 2 * int'(word_len));

	// Table index of the current prefix, or the root entry
	assign bump_sum = root_q ? '0
	                         : kpc_pkg::length_offset(k_q) + kpc_pkg::sum_t'(code_q);
	assign bump_ok  = (bump_sum < kpc_pkg::sum_t'(kpc_pkg::TABLE_DEPTH));

	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = read_index;
			S_BUMP:  rd_addr = bump_sum[IDX_W-1:0];
			default: rd_addr = ridx_q;
		endcase
	end

	// The clearing pass and the read-modify-write share the one write port
	assign mem_we = (state_q == S_CLEAR) || wr_pend_q;
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : wr_addr_q;
	assign mem_wd = (state_q == S_CLEAR) ? '0
	              : (mem_rd_q == {kpc_pkg::COUNT_W{1'b1}}) ? mem_rd_q
	              : mem_rd_q + kpc_pkg::COUNT_W'(1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// Configuration: taken at any time, only written while idle by contract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_order_q <= 3'd2;
			codon_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WORD_ORDER_SEL: word_order_q <= cfg_data;
				REG_CODON_SEL:      codon_mode_q <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	// Sequencer and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			window_q  <= '0;
			seen_q    <= '0;
			phase_q   <= '0;
			wr_pend_q <= 1'b0;
			k_q       <= '0;
			code_q    <= '0;
			root_q    <= 1'b0;
			codon_q   <= 1'b0;
		end else begin
			wr_pend_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(kpc_pkg::TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (kind)
							kpc_pkg::KIND_BASE: begin
								window_q <= window_nx;
								seen_q   <= seen_nx;
								phase_q  <= phase_nx;
								k_q      <= word_len;
								code_q   <= window_nx & win_mask;
								root_q   <= 1'b0;
								codon_q  <= codon_mode_q;
								if (seen_nx >= word_len) begin
									if (!codon_mode_q) begin
										state_q <= S_BUMP;
									end else if (word_len >= K_W'(3) &&
									             phase_nx == kpc_pkg::mod3(word_len)) begin
										state_q <= S_SHIFT;
									end
								end
							end
							kpc_pkg::KIND_END: begin
								window_q <= '0;
								seen_q   <= '0;
								phase_q  <= '0;
							end
							kpc_pkg::KIND_READ: begin
								state_q <= S_RDATA;
							end
							default: ;
						endcase
					end
				end
				S_SHIFT: begin
					// walk the code down to the 3-mer that opens the window
					if (k_q == K_W'(3)) begin
						state_q <= S_BUMP;
					end else begin
						k_q    <= k_q - K_W'(1);
						code_q <= code_q >> 2;
					end
				end
				S_BUMP: begin
					wr_pend_q <= bump_ok;
					if (codon_q || root_q) begin
						state_q <= S_DRAIN;
					end else if (k_q == K_W'(1)) begin
						root_q <= 1'b1;
					end else begin
						k_q    <= k_q - K_W'(1);
						code_q <= code_q >> 2;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				S_RDATA: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_BUMP) begin
			wr_addr_q <= bump_sum[IDX_W-1:0];
		end
		if (accept) begin
			ridx_q <= read_index;
		end
		if (state_q == S_RDATA && out_free) begin
			count_q <= mem_rd_q;
			entry_q <= ridx_q;
		end
	end

	// Result register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RDATA && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign count_value = count_q;
	assign entry_index = entry_q;

endmodule

`default_nettype wire
